// ===== rtl/core/dual_timer_with_watchdog_macros.svh =====
// Assertion macros for the dual timer with watchdog.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DUAL_TIMER_WITH_WATCHDOG_MACROS_SVH
`define DUAL_TIMER_WITH_WATCHDOG_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DTW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dtw_pkg.sv =====
// Shared types and constants for the dual timer with watchdog.
// No dependencies; imported by every module of the block.
package dtw_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;

    // Register word offsets (byte offset / 4)
    localparam logic [4:0] REG_TIM12 = 5'(8'h10 / 4);
    localparam logic [4:0] REG_TIM34 = 5'(8'h14 / 4);
    localparam logic [4:0] REG_PRD12 = 5'(8'h18 / 4);
    localparam logic [4:0] REG_PRD34 = 5'(8'h1c / 4);
    localparam logic [4:0] REG_TCR   = 5'(8'h20 / 4);
    localparam logic [4:0] REG_TGCR  = 5'(8'h24 / 4);
    localparam logic [4:0] REG_WDTCR = 5'(8'h28 / 4);

    // Watchdog service keys and WDTCR layout
    localparam logic [15:0] KEY_FIRST  = 16'ha5c6;
    localparam logic [15:0] KEY_SECOND = 16'hda7e;
    localparam int WDEN_BIT = 14;

    // TCR enable-mode field positions and codes
    localparam int ENAMODE_LO_SHIFT = 6;
    localparam int ENAMODE_HI_SHIFT = 22;
    localparam logic [1:0] ENAMODE_OFF     = 2'd0;
    localparam logic [1:0] ENAMODE_ONESHOT = 2'd1;

    // TGCR timer mode codes (bits 3:2)
    localparam logic [1:0] TIMMODE_UNCHAINED = 2'd1;
    localparam logic [1:0] TIMMODE_WATCHDOG  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        WD_IDLE  = 2'd0,
        WD_PRE   = 2'd1,
        WD_ARMED = 2'd2,
        WD_KEY1  = 2'd3
    } t_wd_phase;

    // One beat being executed this cycle
    typedef struct packed {
        logic        fire;
        t_func       func;
        logic [4:0]  reg_word;
        logic [31:0] data;
    } t_op;

    // Watchdog control toward the counters
    typedef struct packed {
        logic armed;
        logic clear_cnt;
    } t_wd_ctl;

endpackage

// ===== rtl/core/dual_timer_with_watchdog.sv =====
// An accepted input beat reaches its result beat through the input register,
// then the result register. Throughput: one beat per cycle while i_stall is low.
// The rate is set by the combinational tick path: a 2*COUNTER_WIDTH increment
// and equality compare between the input and result registers.
// Reset (i_rst_n low, synchronous) clears all timer and watchdog registers,
// empties both pipeline registers, and is usable on the next cycle.
`include "dual_timer_with_watchdog_macros.svh"
module dual_timer_with_watchdog #(
    parameter int COUNTER_WIDTH = dtw_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_reg_word,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq_low,
    output logic        o_irq_high,
    output logic        o_wd_reset
);
    import dtw_pkg::*;

    // Input register: holds the beat being executed
    logic        r_in_valid;
    logic [1:0]  r_in_func;
    logic [4:0]  r_in_reg_word;
    logic [31:0] r_in_data;

    // Result register: decouples downstream stall from the timer state
    logic        r_out_valid;
    logic [31:0] r_out_read_data;
    logic        r_out_irq_low, r_out_irq_high, r_out_wd_reset;

    logic        out_adv, in_adv;
    t_op         op;
    t_wd_ctl     wd_ctl;
    logic [31:0] cnt_rd_word, wd_rd_word, rd_word;
    logic        irq_low, irq_high, wd_expire, fired_next;

    // The result slot frees when empty or when its beat is taken this cycle;
    // the input slot moves whenever its beat can execute into the result slot.
    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    // The beat in the input register commits its state update exactly when
    // its result is written, so a stalled beat never updates twice.
    assign op.fire     = r_in_valid && out_adv;
    assign op.func     = t_func'(r_in_func);
    assign op.reg_word = r_in_reg_word;
    assign op.data     = r_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_adv) begin
            r_in_func     <= i_func;
            r_in_reg_word <= i_reg_word;
            r_in_data     <= i_write_data;
        end
    end

    dtw_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_wd_ctl    (wd_ctl),
        .o_rd_word   (cnt_rd_word),
        .o_irq_low   (irq_low),
        .o_irq_high  (irq_high),
        .o_wd_expire (wd_expire)
    );

    dtw_wdog u_wdog (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_expire     (wd_expire),
        .o_ctl        (wd_ctl),
        .o_rd_word    (wd_rd_word),
        .o_fired_next (fired_next)
    );

    // Only reads return data; unmapped words decode to zero in both sources
    assign rd_word = (op.func == FUNC_READ) ? (cnt_rd_word | wd_rd_word) : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op.fire) begin
            r_out_read_data <= rd_word;
            r_out_irq_low   <= irq_low;
            r_out_irq_high  <= irq_high;
            r_out_wd_reset  <= fired_next;   // flag as it stands after this beat
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_read_data;
    assign o_irq_low   = r_out_irq_low;
    assign o_irq_high  = r_out_irq_high;
    assign o_wd_reset  = r_out_wd_reset;

    `DTW_ASSERT_NOW(a_stall_needs_beat, i_clk, i_rst_n, o_stall,
        r_in_valid && r_out_valid && i_stall,
        "input stalled without a blocked beat")

endmodule

// ===== rtl/core/dtw_counters.sv =====
// Counter, period, TCR and TGCR registers with tick/compare logic.
// Depends on dtw_pkg; driven by the top level and by dtw_wdog.
`include "dual_timer_with_watchdog_macros.svh"
module dtw_counters #(
    parameter int COUNTER_WIDTH = dtw_pkg::COUNTER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtw_pkg::t_op     i_op,
    input  dtw_pkg::t_wd_ctl i_wd_ctl,
    output logic [31:0]      o_rd_word,
    output logic             o_irq_low,
    output logic             o_irq_high,
    output logic             o_wd_expire
);
    import dtw_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    logic [CW-1:0]   r_cnt_lo, r_cnt_hi, r_prd_lo, r_prd_hi;
    logic [CW-1:0]   n_cnt_lo, n_cnt_hi, n_prd_lo, n_prd_hi;
    logic [31:0]     r_tcr, n_tcr;
    logic [3:0]      r_tgcr, n_tgcr;
    logic [CW-1:0]   inc_lo, inc_hi;
    logic [2*CW-1:0] wd_inc;
    logic [1:0]      mode_lo, mode_hi;

    assign mode_lo = r_tcr[ENAMODE_LO_SHIFT +: 2];
    assign mode_hi = r_tcr[ENAMODE_HI_SHIFT +: 2];
    assign inc_lo  = r_cnt_lo + CW'(1);
    assign inc_hi  = r_cnt_hi + CW'(1);
    assign wd_inc  = {r_cnt_hi, r_cnt_lo} + (2*CW)'(1);

    always_comb begin
        n_cnt_lo    = r_cnt_lo;
        n_cnt_hi    = r_cnt_hi;
        n_prd_lo    = r_prd_lo;
        n_prd_hi    = r_prd_hi;
        n_tcr       = r_tcr;
        n_tgcr      = r_tgcr;
        o_irq_low   = 1'b0;
        o_irq_high  = 1'b0;
        o_wd_expire = 1'b0;
        if (i_op.fire) begin
            case (i_op.func)
                FUNC_TICK: begin
                    if (r_tgcr[3:2] == TIMMODE_UNCHAINED) begin
                        if (r_tgcr[0] && mode_lo != ENAMODE_OFF) begin
                            if (inc_lo == r_prd_lo) begin
                                n_cnt_lo  = '0;
                                o_irq_low = 1'b1;
                                if (mode_lo == ENAMODE_ONESHOT) begin
                                    n_tcr[ENAMODE_LO_SHIFT +: 2] = ENAMODE_OFF;
                                end
                            end else begin
                                n_cnt_lo = inc_lo;
                            end
                        end
                        if (r_tgcr[1] && mode_hi != ENAMODE_OFF) begin
                            if (inc_hi == r_prd_hi) begin
                                n_cnt_hi   = '0;
                                o_irq_high = 1'b1;
                                if (mode_hi == ENAMODE_ONESHOT) begin
                                    n_tcr[ENAMODE_HI_SHIFT +: 2] = ENAMODE_OFF;
                                end
                            end else begin
                                n_cnt_hi = inc_hi;
                            end
                        end
                    end else if (r_tgcr[3:2] == TIMMODE_WATCHDOG && i_wd_ctl.armed) begin
                        if (wd_inc == {r_prd_hi, r_prd_lo}) begin
                            n_cnt_lo    = '0;
                            n_cnt_hi    = '0;
                            o_wd_expire = 1'b1;
                        end else begin
                            {n_cnt_hi, n_cnt_lo} = wd_inc;
                        end
                    end
                end
                FUNC_WRITE: begin
                    case (i_op.reg_word)
                        REG_TIM12: n_cnt_lo = CW'(i_op.data);
                        REG_TIM34: n_cnt_hi = CW'(i_op.data);
                        REG_PRD12: n_prd_lo = CW'(i_op.data);
                        REG_PRD34: n_prd_hi = CW'(i_op.data);
                        REG_TCR:   n_tcr    = i_op.data;
                        REG_TGCR:  n_tgcr   = i_op.data[3:0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        // Second service key restarts the watchdog count
        if (i_wd_ctl.clear_cnt) begin
            n_cnt_lo = '0;
            n_cnt_hi = '0;
        end
    end

    always_comb begin
        case (i_op.reg_word)
            REG_TIM12: o_rd_word = 32'(r_cnt_lo);
            REG_TIM34: o_rd_word = 32'(r_cnt_hi);
            REG_PRD12: o_rd_word = 32'(r_prd_lo);
            REG_PRD34: o_rd_word = 32'(r_prd_hi);
            REG_TCR:   o_rd_word = r_tcr;
            REG_TGCR:  o_rd_word = 32'(r_tgcr);
            default:   o_rd_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            r_prd_lo <= '0;
            r_prd_hi <= '0;
            r_tcr    <= '0;
            r_tgcr   <= '0;
        end else begin
            r_cnt_lo <= n_cnt_lo;
            r_cnt_hi <= n_cnt_hi;
            r_prd_lo <= n_prd_lo;
            r_prd_hi <= n_prd_hi;
            r_tcr    <= n_tcr;
            r_tgcr   <= n_tgcr;
        end
    end

    `DTW_ASSERT_NOW(a_irq_only_unchained, i_clk, i_rst_n,
        o_irq_low || o_irq_high,
        i_op.fire && i_op.func == FUNC_TICK && r_tgcr[3:2] == TIMMODE_UNCHAINED,
        "timer irq outside an unchained tick")
    `DTW_ASSERT_NOW(a_expire_only_armed, i_clk, i_rst_n,
        o_wd_expire, i_wd_ctl.armed && r_tgcr[3:2] == TIMMODE_WATCHDOG,
        "watchdog expiry while not armed in watchdog mode")

endmodule

// ===== rtl/core/dtw_wdog.sv =====
// Watchdog key sequencer: WDTCR storage, arming phases and sticky reset flag.
// Depends on dtw_pkg; exchanges arm/clear and expiry with dtw_counters.
`include "dual_timer_with_watchdog_macros.svh"
module dtw_wdog (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtw_pkg::t_op     i_op,
    input  logic             i_expire,
    output dtw_pkg::t_wd_ctl o_ctl,
    output logic [31:0]      o_rd_word,
    output logic             o_fired_next
);
    import dtw_pkg::*;

    t_wd_phase   r_phase, n_phase;
    logic        r_wden, n_wden;
    logic [13:0] r_wd_data, n_wd_data;
    logic        r_fired, n_fired;
    logic        wr_hit;
    logic [15:0] key;
    logic        wden_w;

    assign wr_hit = i_op.fire && i_op.func == FUNC_WRITE && i_op.reg_word == REG_WDTCR;
    assign key    = i_op.data[31:16];
    assign wden_w = r_wden | i_op.data[WDEN_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= WD_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_wden          = r_wden;
        n_wd_data       = r_wd_data;
        n_fired         = r_fired | i_expire;
        o_ctl.clear_cnt = 1'b0;
        o_ctl.armed     = (r_phase == WD_ARMED) || (r_phase == WD_KEY1);
        if (wr_hit) begin
            n_wden    = wden_w;
            n_wd_data = i_op.data[13:0];
            case (r_phase)
                WD_ARMED: begin
                    if (key == KEY_FIRST) begin
                        n_phase = WD_KEY1;
                    end else begin
                        n_fired = 1'b1;
                    end
                end
                WD_KEY1: begin
                    if (key == KEY_SECOND) begin
                        n_phase         = WD_ARMED;
                        o_ctl.clear_cnt = 1'b1;
                    end else begin
                        n_fired = 1'b1;
                    end
                end
                default: begin
                    if (!wden_w) begin
                        n_phase = WD_IDLE;
                    end else if (key == KEY_FIRST) begin
                        n_phase = WD_PRE;
                    end else if (key == KEY_SECOND && r_phase == WD_PRE) begin
                        n_phase = WD_ARMED;
                    end else begin
                        n_phase = WD_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wden    <= 1'b0;
            r_wd_data <= '0;
            r_fired   <= 1'b0;
        end else begin
            r_wden    <= n_wden;
            r_wd_data <= n_wd_data;
            r_fired   <= n_fired;
        end
    end

    assign o_fired_next = n_fired;
    assign o_rd_word    = (i_op.reg_word == REG_WDTCR) ?
                          {16'h0000, r_fired, r_wden, r_wd_data} : 32'h0000_0000;

    `DTW_ASSERT_NEXT(a_fired_sticky, i_clk, i_rst_n, r_fired, r_fired,
        "watchdog reset flag cleared without reset")
    `DTW_ASSERT_NEXT(a_armed_stays, i_clk, i_rst_n,
        r_phase == WD_ARMED || r_phase == WD_KEY1,
        r_phase == WD_ARMED || r_phase == WD_KEY1,
        "watchdog left the armed phases")
    `DTW_ASSERT_NOW(a_clear_from_key1, i_clk, i_rst_n,
        o_ctl.clear_cnt, r_phase == WD_KEY1 && wr_hit,
        "watchdog count cleared outside the second key")

endmodule

// ===== tb/dual_timer_with_watchdog_test.sv =====
// Self-checking testbench for dual_timer_with_watchdog: the timer halves, the watchdog
// key sequence and the register map, driven beat by beat and checked against a predictor.
// Depends on dtw_pkg and the dual_timer_with_watchdog RTL only.
module dual_timer_with_watchdog_test;
    import dtw_pkg::*;

    localparam int CW = COUNTER_WIDTH_DEF;
    localparam logic [31:0] CNT_MASK = 32'((64'd1 << CW) - 64'd1);

    // Codes the package does not name
    localparam logic [1:0] FUNC_UNUSED      = 2'd3;
    localparam logic [1:0] TIMMODE_GP64     = 2'd0;
    localparam logic [1:0] TIMMODE_CHAINED  = 2'd3;
    localparam logic [1:0] ENAMODE_PERIODIC = 2'd2;
    localparam logic [1:0] ENAMODE_RESERVED = 2'd3;
    localparam logic [4:0] REG_UNMAPPED_LO  = 5'd0;
    localparam logic [4:0] REG_UNMAPPED_HI  = 5'd31;
    localparam logic [15:0] WDEN_MASK       = 16'(1 << WDEN_BIT);

    // Stimulus stages: WDEN never set, WDEN free but no arming, armed watchdog
    typedef enum {STAGE_PLAIN, STAGE_WDEN, STAGE_ARMED} stage_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  reg_word;
        logic [31:0] data;
    } timer_beat_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_low;
        logic        irq_high;
        logic        wd_reset;
    } timer_result_t;

    // Clock, reset and DUT inputs, all known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_func       = '0;
    logic [4:0]  i_reg_word   = '0;
    logic [31:0] i_write_data = '0;
    logic        i_stall      = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_irq_low;
    logic        o_irq_high;
    logic        o_wd_reset;

    dual_timer_with_watchdog i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_reg_word   (i_reg_word),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_irq_low    (o_irq_low),
        .o_irq_high   (o_irq_high),
        .o_wd_reset   (o_wd_reset)
    );

    initial forever #2 i_clk = ~i_clk;

    // Beats waiting to be driven, and results predicted but not yet seen
    timer_beat_t   beats_pending[$];
    timer_result_t results_due[$];

    // Idle rates in percent; the sequencer changes them per stage
    int src_idle_pct  = 6;
    int rcv_stall_pct = 57;

    logic in_fire        = 1'b0;   // request beat taken at the last rising edge
    logic key1_just_sent = 1'b0;   // generator side: last WDTCR key was the first one
    int   beats_queued   = 0;
    int   beats_taken    = 0;
    int   irq_low_seen   = 0;
    int   irq_high_seen  = 0;
    logic wd_seen        = 1'b0;
    int   mismatches     = 0;

    // ------------------------------------------------------------------
    // Predictor state: a copy of the block's registers, reset values zero
    // ------------------------------------------------------------------
    logic [31:0] ctl_tcr   = '0;
    logic [3:0]  ctl_tgcr  = '0;
    logic [31:0] tim_lo    = '0;
    logic [31:0] tim_hi    = '0;
    logic [31:0] prd_lo_q  = '0;
    logic [31:0] prd_hi_q  = '0;
    logic [31:0] wd_ctl    = '0;
    t_wd_phase   wd_state  = WD_IDLE;
    logic        wd_tripped = 1'b0;

    // One 32-bit half counting up: {hit, next count}
    function automatic logic [32:0] half_step(logic [31:0] cnt, logic [31:0] prd);
        logic [31:0] nxt;
        nxt = (cnt + 32'd1) & CNT_MASK;
        if (nxt == prd) return {1'b1, 32'd0};
        return {1'b0, nxt};
    endfunction

    // Applies one beat to the predictor state and returns the result it causes
    function automatic timer_result_t predict_beat(logic [1:0] fn, logic [4:0] rw,
                                                   logic [31:0] wdata);
        timer_result_t res;
        logic [1:0]    tmode;
        logic [1:0]    emode;
        logic [32:0]   stepped;
        logic [15:0]   key;
        logic          wden;
        res   = '0;
        tmode = ctl_tgcr[3:2];
        case (fn)
            FUNC_TICK: begin
                if (tmode == TIMMODE_UNCHAINED) begin
                    // Halves count independently; one-shot drops its enable on a hit
                    emode = ctl_tcr[ENAMODE_LO_SHIFT +: 2];
                    if (ctl_tgcr[0] && emode != ENAMODE_OFF) begin
                        stepped = half_step(tim_lo, prd_lo_q);
                        res.irq_low = stepped[32];
                        tim_lo = stepped[31:0];
                        if (stepped[32] && emode == ENAMODE_ONESHOT)
                            ctl_tcr[ENAMODE_LO_SHIFT +: 2] = ENAMODE_OFF;
                    end
                    emode = ctl_tcr[ENAMODE_HI_SHIFT +: 2];
                    if (ctl_tgcr[1] && emode != ENAMODE_OFF) begin
                        stepped = half_step(tim_hi, prd_hi_q);
                        res.irq_high = stepped[32];
                        tim_hi = stepped[31:0];
                        if (stepped[32] && emode == ENAMODE_ONESHOT)
                            ctl_tcr[ENAMODE_HI_SHIFT +: 2] = ENAMODE_OFF;
                    end
                end else if (tmode == TIMMODE_WATCHDOG &&
                             (wd_state == WD_ARMED || wd_state == WD_KEY1)) begin
                    // Both halves form one wide count toward the wide period
                    tim_lo = (tim_lo + 32'd1) & CNT_MASK;
                    if (tim_lo == 32'd0) tim_hi = (tim_hi + 32'd1) & CNT_MASK;
                    if (tim_lo == prd_lo_q && tim_hi == prd_hi_q) begin
                        wd_tripped = 1'b1;
                        tim_lo = '0;
                        tim_hi = '0;
                    end
                end
            end
            FUNC_READ: begin
                case (rw)
                    REG_TIM12: res.read_data = tim_lo;
                    REG_TIM34: res.read_data = tim_hi;
                    REG_PRD12: res.read_data = prd_lo_q;
                    REG_PRD34: res.read_data = prd_hi_q;
                    REG_TCR:   res.read_data = ctl_tcr;
                    REG_TGCR:  res.read_data = {28'd0, ctl_tgcr};
                    REG_WDTCR: res.read_data = {16'd0, wd_tripped, wd_ctl[14:0]};
                    default:   res.read_data = '0;
                endcase
            end
            FUNC_WRITE: begin
                case (rw)
                    REG_TIM12: tim_lo   = wdata & CNT_MASK;
                    REG_TIM34: tim_hi   = wdata & CNT_MASK;
                    REG_PRD12: prd_lo_q = wdata & CNT_MASK;
                    REG_PRD34: prd_hi_q = wdata & CNT_MASK;
                    REG_TCR:   ctl_tcr  = wdata;
                    REG_TGCR:  ctl_tgcr = wdata[3:0];
                    REG_WDTCR: begin
                        key  = wdata[31:16];
                        wden = wd_ctl[WDEN_BIT] | wdata[WDEN_BIT];   // sticky
                        wd_ctl = 32'(wdata[13:0]);
                        wd_ctl[WDEN_BIT] = wden;
                        if (wd_state == WD_ARMED || wd_state == WD_KEY1) begin
                            // Armed: only the service pair in order is legal
                            if (wd_state == WD_ARMED && key == KEY_FIRST) begin
                                wd_state = WD_KEY1;
                            end else if (wd_state == WD_KEY1 && key == KEY_SECOND) begin
                                wd_state = WD_ARMED;
                                tim_lo = '0;
                                tim_hi = '0;
                            end else begin
                                wd_tripped = 1'b1;
                            end
                        end else if (!wden) begin
                            wd_state = WD_IDLE;
                        end else if (key == KEY_FIRST) begin
                            wd_state = WD_PRE;
                        end else if (key == KEY_SECOND && wd_state == WD_PRE) begin
                            wd_state = WD_ARMED;
                        end else begin
                            wd_state = WD_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;   // unused func code: nothing changes
        endcase
        res.wd_reset = wd_tripped;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    task automatic queue_beat(logic [1:0] fn, logic [4:0] rw, logic [31:0] d);
        beats_pending.push_back({fn, rw, d});
        beats_queued++;
    endtask

    task automatic queue_write(logic [4:0] rw, logic [31:0] d);
        queue_beat(FUNC_WRITE, rw, d);
    endtask

    // Unused fields carry random bits so every input bit toggles
    task automatic queue_read(logic [4:0] rw);
        queue_beat(FUNC_READ, rw, $urandom);
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_beat(FUNC_TICK, 5'($urandom), $urandom);
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'hffff_ffff - 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(0, 6));
        endcase
    endfunction

    // Mostly short periods so interrupts and watchdog hits actually happen
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            2:       return $urandom;
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [31:0] pick_tgcr(stage_t stage);
        logic [31:0] v;
        logic [1:0]  usual;
        logic [1:0]  other;
        v = $urandom;
        if ($urandom_range(0, 3) != 0) v[1:0] = 2'b11;
        usual = (stage == STAGE_ARMED) ? TIMMODE_WATCHDOG : TIMMODE_UNCHAINED;
        other = (stage == STAGE_ARMED) ? TIMMODE_UNCHAINED : TIMMODE_WATCHDOG;
        case ($urandom_range(0, 9))
            0:       v[3:2] = TIMMODE_GP64;
            1:       v[3:2] = TIMMODE_CHAINED;
            2, 3:    v[3:2] = other;
            default: v[3:2] = usual;
        endcase
        return v;
    endfunction

    // One random unit: a tick burst, an access, a key write or noise
    task automatic random_unit(stage_t stage);
        int          sel;
        logic [31:0] d;
        logic [15:0] key;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            queue_ticks($urandom_range(1, 8));
        end else if (sel < 57) begin
            queue_read(5'($urandom_range(REG_TIM12, REG_WDTCR)));
        end else if (sel < 71) begin
            case ($urandom_range(0, 3))
                0: queue_write(REG_TIM12, pick_count());
                1: queue_write(REG_TIM34, pick_count());
                2: queue_write(REG_PRD12, pick_period());
                default: begin
                    // armed stage keeps the upper period at zero most of the time
                    if (stage == STAGE_ARMED && $urandom_range(0, 9) < 7)
                        queue_write(REG_PRD34, 32'd0);
                    else
                        queue_write(REG_PRD34, pick_period());
                end
            endcase
        end else if (sel < 77) begin
            d = $urandom;
            d[ENAMODE_LO_SHIFT +: 2] = 2'($urandom_range(0, 3));
            d[ENAMODE_HI_SHIFT +: 2] = 2'($urandom_range(0, 3));
            queue_write(REG_TCR, d);
        end else if (sel < 82) begin
            queue_write(REG_TGCR, pick_tgcr(stage));
        end else if (sel < 94) begin
            if (stage == STAGE_ARMED) begin
                if ($urandom_range(0, 99) < 85) begin
                    // service pair, sometimes with other beats in between
                    queue_write(REG_WDTCR, {KEY_FIRST, 16'($urandom)});
                    if ($urandom_range(0, 1) != 0) queue_ticks($urandom_range(1, 3));
                    queue_write(REG_WDTCR, {KEY_SECOND, 16'($urandom)});
                end else begin
                    queue_write(REG_WDTCR, $urandom);
                end
            end else begin
                case ($urandom_range(0, 3))
                    0:       key = KEY_FIRST;
                    1:       key = KEY_SECOND;
                    default: key = 16'($urandom);
                endcase
                // keep the watchdog from arming before the last stage
                if (key == KEY_SECOND && key1_just_sent) key = 16'($urandom);
                key1_just_sent = (key == KEY_FIRST);
                d = {key, 16'($urandom)};
                d[WDEN_BIT] = (stage == STAGE_WDEN) ? 1'($urandom_range(0, 1)) : 1'b0;
                queue_write(REG_WDTCR, d);
            end
        end else begin
            queue_beat(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), $urandom);
        end
    endtask

    task automatic fill_random(stage_t stage, int count);
        int start;
        start = beats_queued;
        while (beats_queued - start < count) random_unit(stage);
    endtask

    // Waits until every queued beat has been sent and answered
    task automatic drain();
        while (beats_pending.size() != 0 || i_valid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: new beat or idle at the falling edge; a stalled beat is held
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        timer_beat_t beat;
        i_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (beats_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                beat = beats_pending.pop_front();
                i_func       <= beat.func;
                i_reg_word   <= beat.reg_word;
                i_write_data <= beat.data;
                i_valid      <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on every request beat, checks every result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        timer_result_t want;
        in_fire = i_rst_n && i_valid && !o_stall;
        if (in_fire) begin
            results_due.push_back(predict_beat(i_func, i_reg_word, i_write_data));
            beats_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h %b%b%b",
                         $time, o_read_data, o_irq_low, o_irq_high, o_wd_reset);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("irq_low", 32'(want.irq_low), 32'(o_irq_low));
                check_field("irq_high", 32'(want.irq_high), 32'(o_irq_high));
                check_field("wd_reset", 32'(want.wd_reset), 32'(o_wd_reset));
                irq_low_seen  += int'(o_irq_low);
                irq_high_seen += int'(o_irq_high);
                if (o_wd_reset) wd_seen <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then three stages with different idle patterns
    // ------------------------------------------------------------------
    initial begin : sequencer
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stage 1, sender rarely idle, receiver stalls often.
        // Directed: wrap to a zero period, one-shot high half, reserved mode,
        // a half held in reset, unmapped locations, unused func, keys without
        // WDEN, and a tick in 64-bit GP mode.
        queue_read(REG_TCR);
        queue_read(REG_WDTCR);
        queue_write(REG_TIM12, 32'hffff_ffff);
        queue_write(REG_TCR, (32'(ENAMODE_PERIODIC) << ENAMODE_LO_SHIFT) |
                             (32'(ENAMODE_ONESHOT) << ENAMODE_HI_SHIFT));
        queue_write(REG_TGCR, {28'd0, TIMMODE_UNCHAINED, 2'b11});
        queue_ticks(1);
        queue_write(REG_PRD34, 32'd2);
        queue_ticks(2);
        queue_read(REG_TCR);
        queue_write(REG_TCR, 32'(ENAMODE_RESERVED) << ENAMODE_LO_SHIFT);
        queue_write(REG_PRD12, 32'd3);
        queue_write(REG_TIM12, 32'd1);
        queue_ticks(2);
        queue_write(REG_TGCR, {28'd0, TIMMODE_UNCHAINED, 2'b10});
        queue_ticks(1);
        queue_read(REG_TIM12);
        queue_write(REG_UNMAPPED_LO, $urandom);
        queue_read(REG_UNMAPPED_HI);
        queue_beat(FUNC_UNUSED, REG_UNMAPPED_HI, 32'hffff_ffff);
        queue_write(REG_WDTCR, {KEY_FIRST, 16'h3fff});
        queue_write(REG_WDTCR, {KEY_SECOND, 16'h3fff});
        queue_read(REG_WDTCR);
        queue_write(REG_TIM34, 32'hffff_ffff);
        queue_write(REG_TGCR, {28'd0, TIMMODE_GP64, 2'b11});
        queue_ticks(1);
        queue_read(REG_TIM34);
        fill_random(STAGE_PLAIN, 640);
        drain();

        // Stage 2: idle pattern swapped; WDEN and keys free, no arming
        @(posedge i_clk);
        src_idle_pct  = 57;
        rcv_stall_pct = 6;
        fill_random(STAGE_WDEN, 640);
        drain();

        // Stage 3: no idling. Arm before watchdog mode is selected, service once,
        // let the count hit its period, then a hit across the low word wrap.
        @(posedge i_clk);
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        queue_write(REG_WDTCR, {KEY_FIRST, WDEN_MASK});
        queue_write(REG_WDTCR, {KEY_SECOND, WDEN_MASK});
        queue_write(REG_TGCR, {28'd0, TIMMODE_WATCHDOG, 2'b11});
        queue_write(REG_TIM12, 32'd0);
        queue_write(REG_TIM34, 32'd0);
        queue_write(REG_PRD12, 32'd5);
        queue_write(REG_PRD34, 32'd0);
        queue_ticks(3);
        queue_write(REG_WDTCR, {KEY_FIRST, WDEN_MASK});
        queue_write(REG_WDTCR, {KEY_SECOND, WDEN_MASK});
        queue_read(REG_TIM12);
        queue_ticks(5);
        queue_read(REG_WDTCR);
        queue_write(REG_TIM12, 32'hffff_fffe);
        queue_write(REG_TIM34, 32'd0);
        queue_write(REG_PRD12, 32'd1);
        queue_write(REG_PRD34, 32'd1);
        queue_ticks(3);
        queue_read(REG_TIM12);
        fill_random(STAGE_ARMED, 640);
        drain();

        // Pipeline is two deep; a few more edges catch any stray result beat
        repeat (8) @(negedge i_clk);
        $display("Covered %0d request beats over three idle patterns and watchdog stages.",
                 beats_taken);
        $display("Timer interrupts seen: %0d low, %0d high; watchdog reset raised: %0d.",
                 irq_low_seen, irq_high_seen, wd_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : run_limit
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
